>>> rtl/ectp_pkg.sv
// ----------------------------------------------------------------------------
// ectp_pkg
// Shared types, constants and helper functions of the Euler
// conserved-to-primitive converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ectp_pkg;

    // default fixed-point format
    localparam int ECTP_FRAC_BITS = 16;

    // field widths
    localparam int WORD_W     = 32;
    localparam int GAMMA_W    = 18;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 18;

    // equation modes (code three behaves as scalar)
    localparam logic [MODE_W-1:0] MODE_SCALAR   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_EULER_1D = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EULER_2D = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EQUATION_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAMMA_RATIO   = 1'd1;

    // reset values
    localparam logic [MODE_W-1:0]  MODE_RESET  = MODE_EULER_1D;
    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 18'd91750;

    // per-request control bits carried down the pipeline
    typedef struct packed {
        logic last;    // end-of-sweep marker
        logic euler;   // Euler mode (1D or 2D)
        logic mode2;   // 2D mode
        logic zero;    // density was zero
    } ectp_ctl_t;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    // clamp a wide signed value to the 32-bit signed range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] res;
        begin
            if (x > S32_MAX)
                res = 32'sh7fffffff;
            else if (x < S32_MIN)
                res = 32'sh80000000;
            else
                res = x[31:0];
            return res;
        end
    endfunction

    // magnitude of a 32-bit signed word, exact for the most negative value
    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        logic [31:0] res;
        begin
            res = x[31] ? (~x + 32'd1) : x;
            return res;
        end
    endfunction

    // sign extension to 64 bits
    function automatic logic signed [63:0] sext64(input logic signed [31:0] x);
        logic signed [63:0] res;
        begin
            res = {{32{x[31]}}, x};
            return res;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/ectp_if.sv
// ----------------------------------------------------------------------------
// ectp_if
// Channel interfaces: conserved-cell input, primitive-cell output and
// configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface ectp_in_if import ectp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] density;
    logic signed [WORD_W-1:0] momentum_x;
    logic signed [WORD_W-1:0] momentum_y;
    logic signed [WORD_W-1:0] total_energy;
    logic                     last_cell;

    modport source (output valid, density, momentum_x, momentum_y, total_energy,
                    last_cell, input ready);
    modport sink   (input valid, density, momentum_x, momentum_y, total_energy,
                    last_cell, output ready);
endinterface

interface ectp_out_if import ectp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] density_out;
    logic signed [WORD_W-1:0] velocity_x;
    logic signed [WORD_W-1:0] velocity_y;
    logic signed [WORD_W-1:0] pressure;
    logic signed [WORD_W-1:0] enthalpy;
    logic signed [WORD_W-1:0] gas_term_rt;
    logic                     divide_error;
    logic                     last_cell_out;

    modport source (output valid, density_out, velocity_x, velocity_y, pressure,
                    enthalpy, gas_term_rt, divide_error, last_cell_out, input ready);
    modport sink   (input valid, density_out, velocity_x, velocity_y, pressure,
                    enthalpy, gas_term_rt, divide_error, last_cell_out, output ready);
endinterface

interface ectp_cfg_if import ectp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/ectp_div.sv
// ----------------------------------------------------------------------------
// ectp_div
// Pipelined unsigned restoring divider, one quotient bit per stage,
// with a side tag that travels with each request.
// ----------------------------------------------------------------------------
`default_nettype none

module ectp_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32,
    parameter int TAG_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] tag_in,
    output logic             out_valid,
    output logic [NUM_W-1:0] quo,
    output logic [TAG_W-1:0] tag_out
);

    logic             valid_reg [NUM_W];
    logic [NUM_W-1:0] num_reg   [NUM_W];
    logic [NUM_W-1:0] quo_reg   [NUM_W];
    logic [DEN_W-1:0] rem_reg   [NUM_W];
    logic [DEN_W-1:0] den_reg   [NUM_W];
    logic [TAG_W-1:0] tag_reg   [NUM_W];

    genvar g;
    generate
        for (g = 0; g < NUM_W; g++)
        begin : g_stage
            logic             valid_src;
            logic [NUM_W-1:0] num_src;
            logic [NUM_W-1:0] quo_src;
            logic [DEN_W-1:0] rem_src;
            logic [DEN_W-1:0] den_src;
            logic [TAG_W-1:0] tag_src;
            logic [DEN_W:0]   trial;
            logic [DEN_W:0]   diff;
            logic             qbit;
            logic [DEN_W-1:0] rem_next;
            logic [NUM_W-1:0] num_next;
            logic [NUM_W-1:0] quo_next;

            // stage source: ports for the first stage, previous stage otherwise
            if (g == 0)
            begin : g_first
                assign valid_src = in_valid;
                assign num_src   = num;
                assign quo_src   = '0;
                assign rem_src   = '0;
                assign den_src   = den;
                assign tag_src   = tag_in;
            end
            else
            begin : g_next
                assign valid_src = valid_reg[g-1];
                assign num_src   = num_reg[g-1];
                assign quo_src   = quo_reg[g-1];
                assign rem_src   = rem_reg[g-1];
                assign den_src   = den_reg[g-1];
                assign tag_src   = tag_reg[g-1];
            end

            // one restoring step
            always_comb
            begin
                trial    = {rem_src, num_src[NUM_W-1]};
                diff     = trial - {1'b0, den_src};
                qbit     = (trial >= {1'b0, den_src});
                rem_next = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                num_next = {num_src[NUM_W-2:0], 1'b0};
                quo_next = {quo_src[NUM_W-2:0], qbit};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    valid_reg[g] <= 1'b0;
                else if (en)
                    valid_reg[g] <= valid_src;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[g] <= num_next;
                    quo_reg[g] <= quo_next;
                    rem_reg[g] <= rem_next;
                    den_reg[g] <= den_src;
                    tag_reg[g] <= tag_src;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[NUM_W-1];
    assign quo       = quo_reg[NUM_W-1];
    assign tag_out   = tag_reg[NUM_W-1];

endmodule

`default_nettype wire

>>> rtl/euler_cons_to_prim.sv
// ----------------------------------------------------------------------------
// euler_cons_to_prim
// Conserved-to-primitive conversion of Euler grid cells in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   cells : valid/ready input, one grid cell (density, momenta, energy,
//           last-cell marker) per request.
//   prims : valid/ready output, one primitive cell per input request, in order.
//   cfg   : valid/ready write channel, index 0 equation_mode, 1 gamma_ratio;
//           always ready, write only while no request is in flight.
// The pipeline has one input register, a (32 + FRAC_BITS)-stage divider
// for the three quotients by density (FRAC_BITS is 16 at Q16.16),
// eight arithmetic stages, a 50-stage divider for the enthalpy quotient
// by gamma minus one, and two output stages.
// Throughput is one cell per cycle while the output is not stalled; every divider
// stage retires one quotient bit, so all stages accept a new request each cycle.
// When the receiver stalls the whole pipeline freezes with its contents
// kept, and cells.ready drops in the same cycle.
// Reset clears all valid bits and sets equation_mode to 1D Euler and
// gamma_ratio to 1.4; the block is ready for cells as soon as it is released.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_cons_to_prim import ectp_pkg::*; #(
    parameter int FRAC_BITS = ECTP_FRAC_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    ectp_in_if.sink    cells,
    ectp_out_if.source prims,
    ectp_cfg_if.sink   cfg
);

    localparam int CTL_W  = $bits(ectp_ctl_t);
    localparam int DIV_W  = WORD_W + FRAC_BITS;
    localparam int Q2_W   = 2 * WORD_W - 1 - FRAC_BITS;
    localparam int GE_W   = GAMMA_W + WORD_W + 1;
    localparam int GMAG_W = GAMMA_W + WORD_W;
    localparam int T1_W   = WORD_W + CTL_W + 1;
    localparam int T2_W   = 5 * WORD_W + Q2_W + CTL_W + 1;
    localparam int CW     = ((GAMMA_W > FRAC_BITS + 1) ? GAMMA_W : FRAC_BITS + 1) + 1;
    localparam logic [CW-1:0] ONE_FX = CW'(1) << FRAC_BITS;

    // signed, saturated word from a quotient magnitude and its sign
    function automatic logic signed [31:0] q_to_s32(input logic [DIV_W-1:0] q,
                                                    input logic s);
        logic signed [63:0] ext;
        begin
            ext = $signed({{(64-DIV_W){1'b0}}, q});
            if (s)
                ext = -ext;
            return sat32(ext);
        end
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [MODE_W-1:0]  mode_reg;
    logic [GAMMA_W-1:0] gamma_reg;
    logic [CW-1:0]      gamma_ext;
    logic [GAMMA_W-1:0] gm1;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RESET;
            gamma_reg <= GAMMA_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_EQUATION_MODE: mode_reg  <= cfg.data[MODE_W-1:0];
                REG_GAMMA_RATIO:   gamma_reg <= cfg.data[GAMMA_W-1:0];
                default:           mode_reg  <= mode_reg;
            endcase
        end
    end

    // gamma minus one, clamped to one LSB
    assign gamma_ext = CW'(gamma_reg);
    assign gm1 = (gamma_ext > ONE_FX) ? GAMMA_W'(gamma_ext - ONE_FX) : GAMMA_W'(1);

    // ------------------------------------------------------------------
    // global advance: the pipeline moves unless the output is stalled
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic adv;

    assign adv         = !out_valid_reg || prims.ready;
    assign cells.ready = adv;

    // ------------------------------------------------------------------
    // input stage: magnitudes, signs and mode decode
    // ------------------------------------------------------------------
    logic                     p_valid_reg;
    logic [WORD_W-1:0]        p_den_reg, p_nx_reg, p_ny_reg, p_ne_reg;
    logic                     p_sx_reg, p_sy_reg, p_se_reg;
    logic signed [WORD_W-1:0] p_r_reg;
    ectp_ctl_t                p_ctl_reg;
    ectp_ctl_t                in_ctl;

    always_comb
    begin
        in_ctl.last  = cells.last_cell;
        in_ctl.euler = (mode_reg == MODE_EULER_1D) || (mode_reg == MODE_EULER_2D);
        in_ctl.mode2 = (mode_reg == MODE_EULER_2D);
        in_ctl.zero  = (cells.density == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_den_reg <= mag32(cells.density);
            p_nx_reg  <= mag32(cells.momentum_x);
            p_ny_reg  <= mag32(cells.momentum_y);
            p_ne_reg  <= mag32(cells.total_energy);
            p_sx_reg  <= cells.momentum_x[WORD_W-1] ^ cells.density[WORD_W-1];
            p_sy_reg  <= cells.momentum_y[WORD_W-1] ^ cells.density[WORD_W-1];
            p_se_reg  <= cells.total_energy[WORD_W-1] ^ cells.density[WORD_W-1];
            p_r_reg   <= cells.density;
            p_ctl_reg <= in_ctl;
        end
    end

    // ------------------------------------------------------------------
    // quotients by density: u, v and specific energy
    // ------------------------------------------------------------------
    logic             du_valid, dv_valid, de_valid;
    logic [DIV_W-1:0] du_q, dv_q, de_q;
    logic [T1_W-1:0]  du_tag;
    logic             dv_tag, de_tag;

    ectp_div #(.NUM_W(DIV_W), .DEN_W(WORD_W), .TAG_W(T1_W)) u_div_u (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(p_valid_reg),
        .num({p_nx_reg, {FRAC_BITS{1'b0}}}), .den(p_den_reg),
        .tag_in({p_r_reg, p_ctl_reg, p_sx_reg}),
        .out_valid(du_valid), .quo(du_q), .tag_out(du_tag)
    );

    ectp_div #(.NUM_W(DIV_W), .DEN_W(WORD_W), .TAG_W(1)) u_div_v (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(p_valid_reg),
        .num({p_ny_reg, {FRAC_BITS{1'b0}}}), .den(p_den_reg),
        .tag_in(p_sy_reg),
        .out_valid(dv_valid), .quo(dv_q), .tag_out(dv_tag)
    );

    ectp_div #(.NUM_W(DIV_W), .DEN_W(WORD_W), .TAG_W(1)) u_div_e (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(p_valid_reg),
        .num({p_ne_reg, {FRAC_BITS{1'b0}}}), .den(p_den_reg),
        .tag_in(p_se_reg),
        .out_valid(de_valid), .quo(de_q), .tag_out(de_tag)
    );

    logic signed [WORD_W-1:0] du_r;
    ectp_ctl_t                du_ctl;
    logic                     du_s;

    assign {du_r, du_ctl, du_s} = du_tag;

    // ------------------------------------------------------------------
    // arithmetic stages
    // ------------------------------------------------------------------
    logic                     d_valid_reg, m1_valid_reg, m2_valid_reg, m3_valid_reg;
    logic                     m4_valid_reg, m5_valid_reg, m6_valid_reg, m7_valid_reg;
    logic signed [WORD_W-1:0] d_u_reg, d_v_reg, d_en_reg, d_r_reg;
    ectp_ctl_t                d_ctl_reg;
    logic signed [63:0]       m1_uu_reg, m1_vv_reg;
    logic signed [WORD_W-1:0] m1_u_reg, m1_v_reg, m1_en_reg, m1_r_reg;
    ectp_ctl_t                m1_ctl_reg;
    logic [Q2_W-1:0]          m2_q2_reg;
    logic signed [WORD_W-1:0] m2_u_reg, m2_v_reg, m2_en_reg, m2_r_reg;
    ectp_ctl_t                m2_ctl_reg;
    logic signed [WORD_W-1:0] m3_e_reg, m3_u_reg, m3_v_reg, m3_r_reg;
    logic [Q2_W-1:0]          m3_q2_reg;
    ectp_ctl_t                m3_ctl_reg;
    logic signed [GE_W-1:0]   m4_ge_reg;
    logic signed [WORD_W-1:0] m4_u_reg, m4_v_reg, m4_r_reg;
    logic [Q2_W-1:0]          m4_q2_reg;
    ectp_ctl_t                m4_ctl_reg;
    logic signed [WORD_W-1:0] m5_rt_reg, m5_u_reg, m5_v_reg, m5_r_reg;
    logic [Q2_W-1:0]          m5_q2_reg;
    ectp_ctl_t                m5_ctl_reg;
    logic signed [63:0]       m6_pr_reg;
    logic signed [GE_W-1:0]   m6_grt_reg;
    logic signed [WORD_W-1:0] m6_rt_reg, m6_u_reg, m6_v_reg, m6_r_reg;
    logic [Q2_W-1:0]          m6_q2_reg;
    ectp_ctl_t                m6_ctl_reg;
    logic signed [WORD_W-1:0] m7_p_reg, m7_rt_reg, m7_u_reg, m7_v_reg, m7_r_reg;
    logic [GMAG_W-1:0]        m7_gmag_reg;
    logic                     m7_gs_reg;
    logic [Q2_W-1:0]          m7_q2_reg;
    ectp_ctl_t                m7_ctl_reg;

    logic [63:0]              sq_sum;
    logic signed [63:0]       e_diff;
    logic signed [63:0]       ge_ext;
    logic signed [GE_W-1:0]   grt_abs;

    assign sq_sum  = $unsigned(m1_uu_reg) + $unsigned(m1_vv_reg);
    assign e_diff  = sext64(m2_en_reg) - $signed({{(64-Q2_W){1'b0}}, m2_q2_reg});
    assign ge_ext  = $signed({{(64-GE_W){m4_ge_reg[GE_W-1]}}, m4_ge_reg});
    assign grt_abs = m6_grt_reg[GE_W-1] ? -m6_grt_reg : m6_grt_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // signed quotients, v only in 2D mode
            d_u_reg   <= q_to_s32(du_q, du_s);
            d_v_reg   <= du_ctl.mode2 ? q_to_s32(dv_q, dv_tag) : '0;
            d_en_reg  <= q_to_s32(de_q, de_tag);
            d_r_reg   <= du_r;
            d_ctl_reg <= du_ctl;

            // squares
            m1_uu_reg  <= d_u_reg * d_u_reg;
            m1_vv_reg  <= d_v_reg * d_v_reg;
            m1_u_reg   <= d_u_reg;
            m1_v_reg   <= d_v_reg;
            m1_en_reg  <= d_en_reg;
            m1_r_reg   <= d_r_reg;
            m1_ctl_reg <= d_ctl_reg;

            // kinetic term q2
            m2_q2_reg  <= sq_sum[63:FRAC_BITS+1];
            m2_u_reg   <= m1_u_reg;
            m2_v_reg   <= m1_v_reg;
            m2_en_reg  <= m1_en_reg;
            m2_r_reg   <= m1_r_reg;
            m2_ctl_reg <= m1_ctl_reg;

            // internal energy
            m3_e_reg   <= sat32(e_diff);
            m3_q2_reg  <= m2_q2_reg;
            m3_u_reg   <= m2_u_reg;
            m3_v_reg   <= m2_v_reg;
            m3_r_reg   <= m2_r_reg;
            m3_ctl_reg <= m2_ctl_reg;

            // (gamma - 1) * e
            m4_ge_reg  <= $signed({1'b0, gm1}) * m3_e_reg;
            m4_q2_reg  <= m3_q2_reg;
            m4_u_reg   <= m3_u_reg;
            m4_v_reg   <= m3_v_reg;
            m4_r_reg   <= m3_r_reg;
            m4_ctl_reg <= m3_ctl_reg;

            // RT, floor scaling
            m5_rt_reg  <= sat32(ge_ext >>> FRAC_BITS);
            m5_q2_reg  <= m4_q2_reg;
            m5_u_reg   <= m4_u_reg;
            m5_v_reg   <= m4_v_reg;
            m5_r_reg   <= m4_r_reg;
            m5_ctl_reg <= m4_ctl_reg;

            // r * RT and gamma * RT
            m6_pr_reg  <= m5_r_reg * m5_rt_reg;
            m6_grt_reg <= $signed({1'b0, gamma_reg}) * m5_rt_reg;
            m6_rt_reg  <= m5_rt_reg;
            m6_q2_reg  <= m5_q2_reg;
            m6_u_reg   <= m5_u_reg;
            m6_v_reg   <= m5_v_reg;
            m6_r_reg   <= m5_r_reg;
            m6_ctl_reg <= m5_ctl_reg;

            // pressure, enthalpy numerator magnitude
            m7_p_reg    <= sat32(m6_pr_reg >>> FRAC_BITS);
            m7_gmag_reg <= grt_abs[GMAG_W-1:0];
            m7_gs_reg   <= m6_grt_reg[GE_W-1];
            m7_rt_reg   <= m6_rt_reg;
            m7_q2_reg   <= m6_q2_reg;
            m7_u_reg    <= m6_u_reg;
            m7_v_reg    <= m6_v_reg;
            m7_r_reg    <= m6_r_reg;
            m7_ctl_reg  <= m6_ctl_reg;
        end
    end

    // ------------------------------------------------------------------
    // enthalpy quotient by gamma minus one
    // ------------------------------------------------------------------
    logic              dh_valid;
    logic [GMAG_W-1:0] dh_q;
    logic [T2_W-1:0]   dh_tag;

    ectp_div #(.NUM_W(GMAG_W), .DEN_W(GAMMA_W), .TAG_W(T2_W)) u_div_h (
        .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(m7_valid_reg),
        .num(m7_gmag_reg), .den(gm1),
        .tag_in({m7_r_reg, m7_u_reg, m7_v_reg, m7_p_reg, m7_rt_reg, m7_q2_reg,
                 m7_ctl_reg, m7_gs_reg}),
        .out_valid(dh_valid), .quo(dh_q), .tag_out(dh_tag)
    );

    logic signed [WORD_W-1:0] dh_r, dh_u, dh_v, dh_p, dh_rt;
    logic [Q2_W-1:0]          dh_q2;
    ectp_ctl_t                dh_ctl;
    logic                     dh_s;
    logic signed [63:0]       dh_abs;

    assign {dh_r, dh_u, dh_v, dh_p, dh_rt, dh_q2, dh_ctl, dh_s} = dh_tag;
    assign dh_abs = $signed({{(64-GMAG_W){1'b0}}, dh_q});

    // ------------------------------------------------------------------
    // signed enthalpy quotient, then sum and output register
    // ------------------------------------------------------------------
    logic                     h1_valid_reg;
    logic signed [63:0]       h1_hq_reg;
    logic signed [WORD_W-1:0] h1_r_reg, h1_u_reg, h1_v_reg, h1_p_reg, h1_rt_reg;
    logic [Q2_W-1:0]          h1_q2_reg;
    ectp_ctl_t                h1_ctl_reg;
    logic signed [63:0]       h_sum;
    logic signed [WORD_W-1:0] h_sat;

    logic signed [WORD_W-1:0] dout_reg, u_reg, v_reg, p_reg, h_reg, rt_reg;
    logic                     err_reg, last_reg;

    assign h_sum = h1_hq_reg + $signed({{(64-Q2_W){1'b0}}, h1_q2_reg});
    assign h_sat = sat32(h_sum);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h1_hq_reg  <= dh_s ? -dh_abs : dh_abs;
            h1_r_reg   <= dh_r;
            h1_u_reg   <= dh_u;
            h1_v_reg   <= dh_v;
            h1_p_reg   <= dh_p;
            h1_rt_reg  <= dh_rt;
            h1_q2_reg  <= dh_q2;
            h1_ctl_reg <= dh_ctl;

            last_reg <= h1_ctl_reg.last;
            if (!h1_ctl_reg.euler)
            begin
                // scalar copy
                dout_reg <= h1_r_reg;
                u_reg    <= '0;
                v_reg    <= '0;
                p_reg    <= '0;
                h_reg    <= '0;
                rt_reg   <= '0;
                err_reg  <= 1'b0;
            end
            else if (h1_ctl_reg.zero)
            begin
                // zero density
                dout_reg <= '0;
                u_reg    <= '0;
                v_reg    <= '0;
                p_reg    <= '0;
                h_reg    <= '0;
                rt_reg   <= '0;
                err_reg  <= 1'b1;
            end
            else
            begin
                dout_reg <= h1_r_reg;
                u_reg    <= h1_u_reg;
                v_reg    <= h1_v_reg;
                p_reg    <= h1_p_reg;
                h_reg    <= h_sat;
                rt_reg   <= h1_rt_reg;
                err_reg  <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            m3_valid_reg  <= 1'b0;
            m4_valid_reg  <= 1'b0;
            m5_valid_reg  <= 1'b0;
            m6_valid_reg  <= 1'b0;
            m7_valid_reg  <= 1'b0;
            h1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_valid_reg   <= cells.valid;
            d_valid_reg   <= du_valid;
            m1_valid_reg  <= d_valid_reg;
            m2_valid_reg  <= m1_valid_reg;
            m3_valid_reg  <= m2_valid_reg;
            m4_valid_reg  <= m3_valid_reg;
            m5_valid_reg  <= m4_valid_reg;
            m6_valid_reg  <= m5_valid_reg;
            m7_valid_reg  <= m6_valid_reg;
            h1_valid_reg  <= dh_valid;
            out_valid_reg <= h1_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // outputs
    // ------------------------------------------------------------------
    assign prims.valid         = out_valid_reg;
    assign prims.density_out   = dout_reg;
    assign prims.velocity_x    = u_reg;
    assign prims.velocity_y    = v_reg;
    assign prims.pressure      = p_reg;
    assign prims.enthalpy      = h_reg;
    assign prims.gas_term_rt   = rt_reg;
    assign prims.divide_error  = err_reg;
    assign prims.last_cell_out = last_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // the three density dividers stay in lock step
    a_div_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        (du_valid == dv_valid) && (du_valid == de_valid))
        else $error("density divider lanes out of step");

    // a division error zeroes every value field
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (prims.valid && prims.divide_error) |->
        (prims.density_out == '0) && (prims.velocity_x == '0) &&
        (prims.velocity_y == '0) && (prims.pressure == '0) &&
        (prims.enthalpy == '0) && (prims.gas_term_rt == '0))
        else $error("divide error with non-zero outputs");

    // an output stall freezes the pipeline behind it
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !prims.ready) |=>
        $stable(h1_valid_reg) && $stable(m7_valid_reg) && $stable(p_valid_reg))
        else $error("pipeline moved during output stall");

    // input is refused while a result waits unaccepted
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !prims.ready) |-> !cells.ready)
        else $error("input accepted during output stall");

endmodule

`default_nettype wire
